// ----- rtl/eem_pkg.sv -----
// Shared constants, codes and types of the embedding enroll-and-match block.
package eem_pkg;

   // Geometry
   localparam int EMB_LEN     = 128;
   localparam int MAX_SAMPLES = 16;

   // Field and register widths
   localparam int VALUE_W    = 16;
   localparam int SUM_W      = 20;
   localparam int ACC_W      = 48;
   localparam int THR_W      = 15;
   localparam int SAMP_W     = 5;
   localparam int STATUS_W   = 3;
   localparam int PROG_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;
   localparam int REQ_DATA_W = VALUE_W;
   localparam int RSP_DATA_W = STATUS_W + PROG_W;

   localparam logic [THR_W-1:0]  THR_RESET     = THR_W'(11469);
   localparam logic [SAMP_W-1:0] SAMPLES_RESET = SAMP_W'(10);

   // Derived widths
   localparam int IDX_W      = $clog2(EMB_LEN);
   localparam int CNT_W      = $clog2(EMB_LEN + 1);
   localparam int PEND_W     = $clog2(MAX_SAMPLES + 1);
   localparam int TGT_W      = (PEND_W > SAMP_W) ? PEND_W : SAMP_W;
   localparam int RAM_ADDR_W = IDX_W + 1;
   localparam int RAM_DEPTH  = 2 ** RAM_ADDR_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Distance decision: A = 2^ONE_SQ_SH - T^2, T in Q1.14
   localparam int A_W       = 2 * THR_W + 2;
   localparam int ONE_SQ_SH = 2 * (THR_W - 1) + 1;
   localparam int WIDE_W    = 2 * A_W + 2 * ACC_W;
   localparam int STEP_W    = $clog2(ACC_W);

   localparam int PROD_DR_W = VALUE_W + SUM_W;
   localparam int PROD_PP_W = 2 * VALUE_W;
   localparam int PROD_RR_W = 2 * SUM_W;

   typedef enum logic {
      CMD_ENROLL    = 1'b0,
      CMD_RECOGNIZE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_SAMPLES   = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENROLL_BUSY  = 3'd0,
      ST_ENROLL_DONE  = 3'd1,
      ST_MATCH        = 3'd2,
      ST_NO_MATCH     = 3'd3,
      ST_NOT_ENROLLED = 3'd4
   } status_type;

   // One classified element on its way from front to back
   typedef struct packed {
      cmd_type                    cmd;
      logic                       elem_ok;
      logic [IDX_W-1:0]           idx;
      logic signed [VALUE_W-1:0]  value;
      logic                       last_elem;
   } op_type;

   // Distance unit status toward the back end
   typedef struct packed {
      logic done;
      logic hit;
   } match_rsp_type;

endpackage

// ----- rtl/eem_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module eem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/eem_queue.sv -----
// Short FIFO of classified elements between the front and back ends.
module eem_queue
   import eem_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push_go, pop_go;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slots_ff[rd_ptr_ff];
   assign push_go    = push_valid && push_ready;
   assign pop_go     = pop_valid && pop_ready;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push_go) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop_go) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push_go && !pop_go) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop_go && !push_go) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         slots_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- rtl/eem_front.sv -----
// Front end: takes input items, tracks position and command of the current vector.
module eem_front
   import eem_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      push_valid,
   input  logic                      push_ready,
   output op_type                    push_op
);

   logic [CNT_W-1:0] idx_ff, idx_in;
   cmd_type          cmd_ff, cmd_in;
   cmd_type          cur_cmd;
   logic             elem_ok;
   logic             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // The first element of a vector decides its command
   assign cur_cmd = (idx_ff == '0) ? cmd_type'(req_cmd) : cmd_ff;
   // Elements past the vector length are dropped, but the last one still closes it
   assign elem_ok = (idx_ff < CNT_W'(EMB_LEN));

   always_comb begin
      push_op.cmd       = cur_cmd;
      push_op.elem_ok   = elem_ok;
      push_op.idx       = idx_ff[IDX_W-1:0];
      push_op.value     = req_value;
      push_op.last_elem = req_last;
   end

   always_comb begin
      idx_in = idx_ff;
      cmd_in = cmd_ff;
      if (accept) begin
         cmd_in = cur_cmd;
         if (req_last) begin
            idx_in = '0;
         end else if (elem_ok) begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cmd_ff <= CMD_ENROLL;
      end else begin
         idx_ff <= idx_in;
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ----- rtl/eem_match.sv -----
// Exact normalized-distance decision by a shared shift-add multiplier.
module eem_match
   import eem_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [THR_W-1:0]        threshold,
   input  logic signed [ACC_W-1:0] dot,
   input  logic [ACC_W-1:0]        psq,
   input  logic [ACC_W-1:0]        rsq,
   output match_rsp_type           rsp
);

   typedef enum logic [1:0] {
      M_IDLE,
      M_SIGN,
      M_MUL,
      M_CMP
   } state_type;

   // A^2, A^2*P, A^2*P*R, D^2
   typedef enum logic [1:0] {
      PH_AA,
      PH_AP,
      PH_APR,
      PH_DD
   } phase_type;

   localparam logic [A_W-1:0]    A_ONE     = {{(A_W-1){1'b0}}, 1'b1} << ONE_SQ_SH;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ACC_W - 1);

   state_type               state_ff, state_in;
   phase_type               phase_ff, phase_in;
   logic signed [A_W-1:0]   a_ff, a_in;
   logic signed [ACC_W-1:0] d_ff, d_in;
   logic [ACC_W-1:0]        p_ff, p_in;
   logic [ACC_W-1:0]        r_ff, r_in;
   logic [WIDE_W-1:0]       mcand_ff, mcand_in;
   logic [ACC_W-1:0]        mplier_ff, mplier_in;
   logic [WIDE_W-1:0]       acc_ff, acc_in;
   logic [WIDE_W-1:0]       lhs_ff, lhs_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    done_ff, done_in;
   logic                    hit_ff, hit_in;

   logic [2*THR_W-1:0]      thr_sq;
   logic                    a_neg, d_neg, d_zero;
   logic [A_W-1:0]          a_mag;
   logic [ACC_W-1:0]        d_mag;
   logic [WIDE_W-1:0]       acc_next;

   assign thr_sq   = threshold * threshold;
   assign a_neg    = a_ff[A_W-1];
   assign d_neg    = d_ff[ACC_W-1];
   assign d_zero   = (d_ff == '0);
   assign a_mag    = a_neg ? (~a_ff + A_W'(1)) : a_ff;
   assign d_mag    = d_neg ? (~d_ff + ACC_W'(1)) : d_ff;
   assign acc_next = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   assign rsp.done = done_ff;
   assign rsp.hit  = hit_ff;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      a_in      = a_ff;
      d_in      = d_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      lhs_in    = lhs_ff;
      step_in   = step_ff;
      done_in   = done_ff;
      hit_in    = hit_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               a_in     = $signed(A_ONE - A_W'(thr_sq));
               d_in     = dot;
               p_in     = psq;
               r_in     = rsq;
               done_in  = 1'b0;
               state_in = M_SIGN;
            end
         end
         M_SIGN: begin
            // Opposite signs of A and D settle the answer without products
            if (!a_neg && (d_neg || d_zero)) begin
               hit_in   = 1'b0;
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else if (a_neg && !d_neg) begin
               hit_in   = 1'b1;
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               mcand_in  = WIDE_W'(a_mag);
               mplier_in = ACC_W'(a_mag);
               acc_in    = '0;
               step_in   = '0;
               phase_in  = PH_AA;
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            acc_in    = acc_next;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               acc_in  = '0;
               step_in = '0;
               case (phase_ff)
                  PH_AA: begin
                     mcand_in  = acc_next;
                     mplier_in = p_ff;
                     phase_in  = PH_AP;
                  end
                  PH_AP: begin
                     mcand_in  = acc_next;
                     mplier_in = r_ff;
                     phase_in  = PH_APR;
                  end
                  PH_APR: begin
                     lhs_in    = acc_next;
                     mcand_in  = WIDE_W'(d_mag);
                     mplier_in = d_mag;
                     phase_in  = PH_DD;
                  end
                  PH_DD: begin
                     acc_in   = acc_next << (2 * ONE_SQ_SH);
                     state_in = M_CMP;
                  end
                  default: begin
                     state_in = M_IDLE;
                  end
               endcase
            end
         end
         M_CMP: begin
            hit_in   = a_neg ? (lhs_ff > acc_ff) : (lhs_ff < acc_ff);
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      phase_ff  <= phase_in;
      a_ff      <= a_in;
      d_ff      <= d_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      lhs_ff    <= lhs_in;
      step_ff   <= step_in;
      hit_ff    <= hit_in;
   end

endmodule

// ----- rtl/eem_back.sv -----
// Back end: sample-sum store, recognize accumulators, enrollment control, result register.
module eem_back
   import eem_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  op_type              pop_op,
   input  logic [THR_W-1:0]    threshold,
   input  logic [SAMP_W-1:0]   samples,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PROG_W-1:0]   rsp_progress
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENR_ADD,
      S_PRB_MUL,
      S_PRB_ACC,
      S_FINAL,
      S_MATCH
   } state_type;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
      logic signed [ACC_W-1:0] r;
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

   state_type                   state_ff, state_in;
   op_type                      op_ff, op_in;
   logic                        use_ref_ff, use_ref_in;
   logic                        bank_ff, bank_in;
   logic                        enrolled_ff, enrolled_in;
   logic [PEND_W-1:0]           pend_cnt_ff, pend_cnt_in;
   logic [CNT_W-1:0]            pend_len_ff, pend_len_in;
   logic [CNT_W-1:0]            enr_len_ff, enr_len_in;
   logic signed [ACC_W-1:0]     dot_ff, dot_in;
   logic signed [ACC_W-1:0]     psq_ff, psq_in;
   logic signed [ACC_W-1:0]     rsq_ff, rsq_in;
   logic signed [PROD_DR_W-1:0] prod_dr_ff, prod_dr_in;
   logic signed [PROD_PP_W-1:0] prod_pp_ff, prod_pp_in;
   logic signed [PROD_RR_W-1:0] prod_rr_ff, prod_rr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [PROG_W-1:0]           rsp_progress_ff, rsp_progress_in;

   logic                        wr_en, rd_en;
   logic [RAM_ADDR_W-1:0]       wr_addr, rd_addr;
   logic [SUM_W-1:0]            wr_data, rd_data;
   logic                        match_start;
   match_rsp_type               match_rsp;

   logic                        out_free;
   logic signed [SUM_W-1:0]     ref_val;
   logic signed [SUM_W:0]       enr_sum;
   logic signed [SUM_W-1:0]     enr_sat;
   logic [TGT_W-1:0]            target;
   logic [PEND_W-1:0]           cnt_inc;
   logic                        reach;

   eem_ram #(
      .WIDTH (SUM_W),
      .DEPTH (RAM_DEPTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   eem_match u_match (
      .clock     (clock),
      .reset     (reset),
      .start     (match_start),
      .threshold (threshold),
      .dot       (dot_ff),
      .psq       (psq_ff),
      .rsq       (rsq_ff),
      .rsp       (match_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ref_val  = use_ref_ff ? $signed(rd_data) : '0;

   // Saturating update of a pending sum
   assign enr_sum = (SUM_W + 1)'($signed(rd_data)) + (SUM_W + 1)'(op_ff.value);
   always_comb begin
      if (enr_sum[SUM_W] != enr_sum[SUM_W-1]) begin
         enr_sat = enr_sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         enr_sat = enr_sum[SUM_W-1:0];
      end
   end

   // Zero samples act as one, counts above the store's limit are clamped
   always_comb begin
      if (samples == '0) begin
         target = TGT_W'(1);
      end else if (TGT_W'(samples) > TGT_W'(MAX_SAMPLES)) begin
         target = TGT_W'(MAX_SAMPLES);
      end else begin
         target = TGT_W'(samples);
      end
   end
   assign cnt_inc = pend_cnt_ff + PEND_W'(1);
   assign reach   = (TGT_W'(cnt_inc) >= target);

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      use_ref_in      = use_ref_ff;
      bank_in         = bank_ff;
      enrolled_in     = enrolled_ff;
      pend_cnt_in     = pend_cnt_ff;
      pend_len_in     = pend_len_ff;
      enr_len_in      = enr_len_ff;
      dot_in          = dot_ff;
      psq_in          = psq_ff;
      rsq_in          = rsq_ff;
      prod_dr_in      = prod_dr_ff;
      prod_pp_in      = prod_pp_ff;
      prod_rr_in      = prod_rr_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_progress_in = rsp_progress_ff;
      pop_ready       = 1'b0;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '0;
      rd_en           = 1'b0;
      rd_addr         = '0;
      match_start     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               op_in    = pop_op;
               state_in = pop_op.last_elem ? S_FINAL : S_IDLE;
               if (pop_op.elem_ok && (pop_op.cmd == CMD_ENROLL)) begin
                  if (pend_cnt_ff == '0) begin
                     // First sample defines the reference length
                     wr_en       = 1'b1;
                     wr_addr     = {~bank_ff, pop_op.idx};
                     wr_data     = SUM_W'(pop_op.value);
                     pend_len_in = CNT_W'(pop_op.idx) + CNT_W'(1);
                  end else if (CNT_W'(pop_op.idx) < pend_len_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = {~bank_ff, pop_op.idx};
                     state_in = S_ENR_ADD;
                  end
               end else if (pop_op.elem_ok) begin
                  // Past the reference length the probe meets zeros
                  use_ref_in = enrolled_ff && (CNT_W'(pop_op.idx) < enr_len_ff);
                  rd_en      = use_ref_in;
                  rd_addr    = {bank_ff, pop_op.idx};
                  state_in   = S_PRB_MUL;
               end
            end
         end
         S_ENR_ADD: begin
            wr_en    = 1'b1;
            wr_addr  = {~bank_ff, op_ff.idx};
            wr_data  = enr_sat;
            state_in = op_ff.last_elem ? S_FINAL : S_IDLE;
         end
         S_PRB_MUL: begin
            prod_dr_in = op_ff.value * ref_val;
            prod_pp_in = op_ff.value * op_ff.value;
            prod_rr_in = ref_val * ref_val;
            state_in   = S_PRB_ACC;
         end
         S_PRB_ACC: begin
            dot_in   = sat_acc((ACC_W + 1)'(dot_ff) + (ACC_W + 1)'(prod_dr_ff));
            psq_in   = sat_acc((ACC_W + 1)'(psq_ff) + (ACC_W + 1)'(prod_pp_ff));
            rsq_in   = sat_acc((ACC_W + 1)'(rsq_ff) + (ACC_W + 1)'(prod_rr_ff));
            state_in = op_ff.last_elem ? S_FINAL : S_IDLE;
         end
         S_FINAL: begin
            if (op_ff.cmd == CMD_ENROLL) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (reach) begin
                     bank_in         = ~bank_ff;
                     enrolled_in     = 1'b1;
                     enr_len_in      = pend_len_ff;
                     pend_cnt_in     = '0;
                     rsp_status_in   = ST_ENROLL_DONE;
                     rsp_progress_in = '0;
                  end else begin
                     pend_cnt_in     = cnt_inc;
                     rsp_status_in   = ST_ENROLL_BUSY;
                     rsp_progress_in = PROG_W'(cnt_inc);
                  end
               end
            end else if (!enrolled_ff || (psq_ff == '0) || (rsq_ff == '0)) begin
               if (out_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = enrolled_ff ? ST_NO_MATCH : ST_NOT_ENROLLED;
                  rsp_progress_in = PROG_W'(pend_cnt_ff);
                  dot_in          = '0;
                  psq_in          = '0;
                  rsq_in          = '0;
                  state_in        = S_IDLE;
               end
            end else begin
               match_start = 1'b1;
               state_in    = S_MATCH;
            end
         end
         S_MATCH: begin
            if (match_rsp.done && out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = match_rsp.hit ? ST_MATCH : ST_NO_MATCH;
               rsp_progress_in = PROG_W'(pend_cnt_ff);
               dot_in          = '0;
               psq_in          = '0;
               rsq_in          = '0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         enrolled_ff  <= 1'b0;
         pend_cnt_ff  <= '0;
         pend_len_ff  <= '0;
         enr_len_ff   <= '0;
         dot_ff       <= '0;
         psq_ff       <= '0;
         rsq_ff       <= '0;
         use_ref_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         enrolled_ff  <= enrolled_in;
         pend_cnt_ff  <= pend_cnt_in;
         pend_len_ff  <= pend_len_in;
         enr_len_ff   <= enr_len_in;
         dot_ff       <= dot_in;
         psq_ff       <= psq_in;
         rsq_ff       <= rsq_in;
         use_ref_ff   <= use_ref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      prod_dr_ff      <= prod_dr_in;
      prod_pp_ff      <= prod_pp_in;
      prod_rr_ff      <= prod_rr_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_progress_ff <= rsp_progress_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_progress = rsp_progress_ff;

endmodule

// ----- rtl/embedding_enroll_and_match.sv -----
// Top level of the embedding enroll-and-match block.
//
// Embedding elements enter on the req stream, one signed Q3.12 element per
// item, tlast on the last element of a vector and tuser giving the command
// (enroll sample or recognize probe) taken from the vector's first element.
// Exactly one item leaves on the rsp stream per vector, after its last
// element: status in the low three bits, pending sample count above it.
// The csr channel sets the match threshold (index 0) and the samples per
// enrollment (index 1); it is always ready. The user must see that it is
// written only while idle; the block itself does not enforce this. The back
// end handles a first enroll sample or a dropped element in its idle state,
// reads and writes back a later sample, and reads, multiplies and accumulates
// a probe element; the last element adds a final state. A probe needing no
// products is answered directly; others are decided by signs where they
// differ, else by the shared shift-add multiplier. A two-item queue lets the
// front keep taking elements while the back works or a result waits. When
// rsp_tready is low the result holds in its output register; the back still
// takes elements up to the next last element, then the queue fills and
// req_tready drops. Reset clears enrollment, counters and accumulators; the
// sample sums need no clearing and are never read before written.
module embedding_enroll_and_match
   import eem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] value
   input  logic                  req_tuser,   // [0] cmd
   input  logic                  req_tlast,   // last element of the vector

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] status, [7:3] progress

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [SAMP_W-1:0]   samples_ff, samples_in;

   logic                push_valid, push_ready;
   op_type              push_op;
   logic                pop_valid, pop_ready;
   op_type              pop_op;
   logic [STATUS_W-1:0] rsp_status;
   logic [PROG_W-1:0]   rsp_progress;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in     = thr_ff;
      samples_in = samples_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in     = csr_data[THR_W-1:0];
            CSR_SAMPLES:   samples_in = csr_data[SAMP_W-1:0];
            default:       thr_in     = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THR_RESET;
         samples_ff <= SAMPLES_RESET;
      end else begin
         thr_ff     <= thr_in;
         samples_ff <= samples_in;
      end
   end

   // Classify each element: vector command, position, dropped or not
   eem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_value  ($signed(req_tdata[VALUE_W-1:0])),
      .req_last   (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   eem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Sums, accumulators, enrollment bookkeeping and decision
   eem_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_op       (pop_op),
      .threshold    (thr_ff),
      .samples      (samples_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_progress (rsp_progress)
   );

   assign rsp_tdata = {rsp_progress, rsp_status};

endmodule

// ----- rtl/eem_checker.sv -----
// Port-level checks of the embedding enroll-and-match block, bound to the top level.
module eem_checker
   import eem_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] status;
   logic [PROG_W-1:0]   progress;

   assign status   = rsp_tdata[STATUS_W-1:0];
   assign progress = rsp_tdata[STATUS_W +: PROG_W];

   // A stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Completing an enrollment empties the pending count
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_ENROLL_DONE) |-> (progress == '0))
      else $error("enroll complete with nonzero progress");

   // An enrollment still in progress has counted at least this sample
   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_ENROLL_BUSY) |-> (progress != '0))
      else $error("enroll in progress with zero progress");

   // Nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind embedding_enroll_and_match eem_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/embedding_enroll_and_match_tb.sv -----
// Self-checking testbench for the embedding enroll-and-match block.
module embedding_enroll_and_match_tb
   import eem_pkg::*;
();

   // One element on the req stream
   typedef struct packed {
      cmd_type                   cmd;
      logic signed [VALUE_W-1:0] value;
      logic                      is_final;
   } element_type;

   // One expected rsp item
   typedef struct {
      status_type          status;
      logic [PROG_W-1:0]   progress;
   } verdict_type;

   localparam int    QUIET_LIMIT   = 4000;   // cycles with no handshake at all
   localparam int    SETTLE_CYCLES = 250;    // covers a full distance decision
   localparam int    BASE_DEPTH    = EMB_LEN + 8;
   localparam int    WIDE          = 192;    // A^2*P*R and 2^58*D^2 both fit
   localparam int    VALUE_MAX     = (1 << (VALUE_W - 1)) - 1;
   localparam int    VALUE_MIN     = -(1 << (VALUE_W - 1));
   localparam longint SUM_HI       = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_LO       = -(longint'(1) << (SUM_W - 1));
   localparam longint ACC_HI       = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint ACC_LO       = -(longint'(1) << (ACC_W - 1));

   // Vector shapes used by the stimulus
   localparam int SHAPE_NEAR   = 0;   // enrolled direction plus noise
   localparam int SHAPE_SCALED = 1;   // same direction, a quarter of the size
   localparam int SHAPE_FLIP   = 2;   // opposite direction
   localparam int SHAPE_WILD   = 3;   // full-range random
   localparam int SHAPE_ZERO   = 4;   // all zero

   // Stall sides
   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [15:0] value
   logic                  req_tuser  = 1'b0; // [0] cmd
   logic                  req_tlast  = 1'b0; // last element of the vector

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [2:0] status, [7:3] progress

   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   embedding_enroll_and_match u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the block: sample-sum banks, enrollment bookkeeping,
   // probe accumulators and the two registers.
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] sums [0:2*EMB_LEN-1];
   int unsigned             bank_sel  = 0;     // bank holding the reference
   logic                    enrolled  = 1'b0;
   int unsigned             pend_cnt  = 0;     // samples summed so far
   int unsigned             elem_idx  = 0;
   cmd_type                 vec_cmd   = CMD_ENROLL;
   int unsigned             pend_len  = 0;     // length of the pending sum
   int unsigned             ref_len   = 0;     // length of the reference
   logic signed [ACC_W-1:0] dot_acc   = '0;
   logic signed [ACC_W-1:0] probe_sq  = '0;
   logic signed [ACC_W-1:0] ref_sq    = '0;
   logic [THR_W-1:0]        thr       = THR_RESET;
   logic [SAMP_W-1:0]       samples   = SAMPLES_RESET;

   element_type pending_elems [$];     // elements not yet offered to the block
   verdict_type awaited_verdicts [$];  // results predicted but not yet seen
   element_type cur_elem;              // element currently on the req bus

   int fail_count    = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int calm_left [2] = '{0, 0};

   int base_vec [0:BASE_DEPTH-1];   // direction that well-formed vectors follow
   int base_len      = 4;
   int queued_items  = 0;
   int queued_results = 0;

   function automatic longint clip(longint x, longint lo, longint hi);
      return (x > hi) ? hi : ((x < lo) ? lo : x);
   endfunction

   // Normalized distance below threshold, done without any rounding:
   // A*sqrt(P*R) < 2^29*D with A = 2^29 - T^2, squared on both sides.
   function automatic logic within_limit();
      longint            a;
      longint            d;
      logic [63:0]       amag;
      logic [63:0]       dmag;
      logic [WIDE-1:0]   lhs;
      logic [WIDE-1:0]   rhs;
      a = (longint'(1) << ONE_SQ_SH) - longint'(thr) * longint'(thr);
      d = longint'(dot_acc);
      // Sign of each side settles it when they differ
      if (a >= 0 && d <= 0)
         return 1'b0;
      if (a < 0 && d >= 0)
         return 1'b1;
      amag = (a < 0) ? -a : a;
      dmag = (d < 0) ? -d : d;
      lhs = WIDE'(amag) * WIDE'(amag) * WIDE'($unsigned(probe_sq)) * WIDE'($unsigned(ref_sq));
      rhs = (WIDE'(dmag) * WIDE'(dmag)) << (2 * ONE_SQ_SH);
      return (a >= 0) ? (lhs < rhs) : (lhs > rhs);
   endfunction

   // Apply one accepted element; a final element adds one expected result.
   task automatic predict_element(cmd_type c, logic signed [VALUE_W-1:0] v, logic fin);
      int unsigned idx;
      int unsigned pos;
      int unsigned tgt;
      longint      r;
      verdict_type res;
      idx = elem_idx;
      // command of a vector comes from its first element only
      if (idx == 0)
         vec_cmd = c;
      // elements past the vector length are dropped until the final one
      if (idx < EMB_LEN) begin
         if (vec_cmd == CMD_ENROLL) begin
            pos = (bank_sel ^ 1) * EMB_LEN + idx;
            if (pend_cnt == 0) begin
               sums[pos] = SUM_W'(v);
               pend_len  = idx + 1;
            end else if (idx < pend_len) begin
               sums[pos] = SUM_W'(clip(longint'(sums[pos]) + longint'(v), SUM_LO, SUM_HI));
            end
         end else begin
            // probe elements past the reference meet zero
            r = 0;
            if (enrolled && idx < ref_len)
               r = longint'(sums[bank_sel * EMB_LEN + idx]);
            dot_acc  = ACC_W'(clip(longint'(dot_acc) + longint'(v) * r, ACC_LO, ACC_HI));
            probe_sq = ACC_W'(clip(longint'(probe_sq) + longint'(v) * longint'(v),
                                   ACC_LO, ACC_HI));
            ref_sq   = ACC_W'(clip(longint'(ref_sq) + r * r, ACC_LO, ACC_HI));
         end
         elem_idx = idx + 1;
      end
      if (fin) begin
         if (vec_cmd == CMD_ENROLL) begin
            // zero samples act as one, too many as the maximum
            tgt = (samples == 0) ? 1 : ((samples > MAX_SAMPLES) ? MAX_SAMPLES : samples);
            pend_cnt++;
            if (pend_cnt >= tgt) begin
               bank_sel ^= 1;
               enrolled = 1'b1;
               ref_len  = pend_len;
               pend_cnt = 0;
               res.status = ST_ENROLL_DONE;
            end else begin
               res.status = ST_ENROLL_BUSY;
            end
         end else begin
            if (!enrolled)
               res.status = ST_NOT_ENROLLED;
            else if (probe_sq == 0 || ref_sq == 0)
               res.status = ST_NO_MATCH;     // a zero norm never matches
            else
               res.status = within_limit() ? ST_MATCH : ST_NO_MATCH;
            dot_acc  = '0;
            probe_sq = '0;
            ref_sq   = '0;
         end
         elem_idx     = 0;
         res.progress = pend_cnt[PROG_W-1:0];
         awaited_verdicts.insert(awaited_verdicts.size(), res);
      end
   endtask

   // Random stall with occasional stretches of none
   function automatic bit pick_stall(int side, int pct);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 1'b0;
      end
      if ($urandom_range(0, 49) == 0)
         calm_left[side] = $urandom_range(10, 40);
      return $urandom_range(0, 99) < pct;
   endfunction

   // ---------------------------------------------------------------------
   // req driver: holds an element until accepted, predicts on acceptance,
   // then offers the next one unless it decides to idle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : feed_elements
      logic busy;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_element(cur_elem.cmd, cur_elem.value, cur_elem.is_final);
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending_elems.size() > 0 && !pick_stall(SIDE_REQ, send_idle_pct)) begin
               cur_elem   = pending_elems.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= cur_elem.value;
               req_tuser  <= cur_elem.cmd;
               req_tlast  <= cur_elem.is_final;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor: every accepted result is matched against the oldest
   // expectation, status and progress separately.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual status %0d progress %0d",
                        $time, rsp_tdata[STATUS_W-1:0], rsp_tdata[RSP_DATA_W-1:STATUS_W]);
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_tdata[STATUS_W-1:0] !== want.status) begin
                  fail_count++;
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_tdata[STATUS_W-1:0]);
               end
               if (rsp_tdata[RSP_DATA_W-1:STATUS_W] !== want.progress) begin
                  fail_count++;
                  $display("%0t: progress mismatch, expected %0d actual %0d",
                           $time, want.progress, rsp_tdata[RSP_DATA_W-1:STATUS_W]);
               end
            end
         end
         rsp_tready <= !pick_stall(SIDE_RSP, recv_idle_pct);
      end
   end

   // Watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Register write; only called with the block idle
   task automatic write_csr(csr_index_type idx, int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_THRESHOLD)
         thr = THR_W'(val);
      else
         samples = SAMP_W'(val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_element(cmd_type c, int val, logic fin);
      element_type e;
      e.cmd      = c;
      e.value    = val[VALUE_W-1:0];
      e.is_final = fin;
      pending_elems.insert(pending_elems.size(), e);
   endtask

   // Mostly the current base length; now and then a mismatch or a vector at
   // and past the full length.
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 24);
      if (r == 0)
         return EMB_LEN + $urandom_range(0, 6);
      if (r < 4)
         return $urandom_range(1, base_len + 4);
      return base_len;
   endfunction

   task automatic queue_vector(cmd_type c, int n, int shape, int amp);
      int              val;
      logic [VALUE_W-1:0] raw;
      cmd_type         ec;
      for (int i = 0; i < n; i++) begin
         case (shape)
            SHAPE_NEAR:   val = base_vec[i];
            SHAPE_SCALED: val = base_vec[i] / 4;
            SHAPE_FLIP:   val = -base_vec[i];
            SHAPE_WILD: begin
               raw = $urandom;
               val = int'($signed(raw));
            end
            default:      val = 0;
         endcase
         if (amp > 0)
            val += int'($urandom_range(0, 2 * amp)) - amp;
         if (val > VALUE_MAX) val = VALUE_MAX;
         if (val < VALUE_MIN) val = VALUE_MIN;
         // later elements sometimes carry the other command; it must be ignored
         ec = (i > 0 && $urandom_range(0, 24) == 0) ? cmd_type'(~c) : c;
         add_element(ec, val, i == n - 1);
      end
      queued_items += n;
      queued_results++;
   endtask

   // Wait until everything is through, then let a decision in flight finish
   task automatic settle();
      while (pending_elems.size() != 0 || req_tvalid || awaited_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase: registers, idling mix, a fresh direction, then
   // mostly enroll/probe traffic around it with some noise vectors.
   task automatic run_phase(int unsigned t, int unsigned s, int spct, int rpct);
      int first_items;
      int first_results;
      int r;
      logic [VALUE_W-1:0] raw;
      write_csr(CSR_THRESHOLD, t);
      write_csr(CSR_SAMPLES, s);
      send_idle_pct = spct;
      recv_idle_pct = rpct;
      base_len = $urandom_range(2, 12);
      for (int i = 0; i < BASE_DEPTH; i++) begin
         raw = $urandom;
         base_vec[i] = int'($signed(raw));
      end
      first_items   = queued_items;
      first_results = queued_results;
      while (queued_items - first_items < 110 || queued_results - first_results < 10) begin
         r = $urandom_range(0, 9);
         if (r < 3)
            queue_vector(CMD_ENROLL, pick_len(), SHAPE_NEAR, $urandom_range(0, 2048));
         else if (r < 8)
            queue_vector(CMD_RECOGNIZE, pick_len(), $urandom_range(SHAPE_NEAR, SHAPE_FLIP),
                         ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(8, 14)));
         else
            queue_vector(cmd_type'($urandom_range(0, 1)), $urandom_range(1, 8),
                         $urandom_range(SHAPE_WILD, SHAPE_ZERO), 0);
      end
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      foreach (sums[i]) sums[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: single-sample enrollment so each case is one vector
      write_csr(CSR_SAMPLES, 1);
      write_csr(CSR_THRESHOLD, THR_RESET);
      send_idle_pct = 27;
      recv_idle_pct = 63;
      add_element(CMD_RECOGNIZE, VALUE_MIN, 1'b1);   // probe before any enrollment
      add_element(CMD_ENROLL, VALUE_MAX, 1'b1);      // enroll the positive extreme
      add_element(CMD_RECOGNIZE, VALUE_MAX, 1'b1);   // identical direction
      add_element(CMD_RECOGNIZE, 0, 1'b1);           // zero probe norm
      add_element(CMD_RECOGNIZE, VALUE_MIN, 1'b1);   // opposite direction
      add_element(CMD_RECOGNIZE, 100, 1'b0);         // probe longer than reference,
      add_element(CMD_ENROLL, 200, 1'b1);            // second cmd must be ignored
      add_element(CMD_ENROLL, 0, 1'b0);              // zero reference
      add_element(CMD_ENROLL, 0, 1'b0);
      add_element(CMD_ENROLL, 0, 1'b1);
      add_element(CMD_RECOGNIZE, 5, 1'b0);           // zero reference norm
      add_element(CMD_RECOGNIZE, 6, 1'b0);
      add_element(CMD_RECOGNIZE, 7, 1'b1);
      add_element(CMD_ENROLL, 1000, 1'b0);           // enroll with stray probe cmd
      add_element(CMD_RECOGNIZE, -1000, 1'b0);
      add_element(CMD_ENROLL, 4096, 1'b1);
      add_element(CMD_RECOGNIZE, 1000, 1'b0);        // matching probe
      add_element(CMD_RECOGNIZE, -1000, 1'b0);
      add_element(CMD_RECOGNIZE, 4096, 1'b1);
      settle();

      // Random phases; samples of 16 leave a partial enrollment that the
      // next phase's out-of-range zero setting completes on its next sample.
      run_phase(11469, 2, 27, 63);
      run_phase(0, 16, 63, 27);                      // threshold zero never matches
      run_phase(32767, 0, 0, 0);                     // widest threshold, zero samples
      run_phase($urandom_range(0, 32767), 31, 0, 0); // samples above the maximum

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
